[sv/spi_pkg.sv]
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants of the segment projection interpolator
// Word layout, derived arithmetic widths, status codes and angle constants.
// ----------------------------------------------------------------------------
package spi_pkg;

   // word format
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // arithmetic widths
   localparam int DIFF_W      = WORD_BITS + 1;     // difference of two words
   localparam int YAW_W       = DIFF_W + 1;        // wrapped heading difference
   localparam int PROD_W      = 2 * DIFF_W;        // product of two differences
   localparam int DOT_W       = PROD_W + 1;        // sum of two products
   localparam int RAD_W       = PROD_W;            // squared segment length
   localparam int ROOT_W      = DIFF_W;            // segment length
   localparam int SQRT_STAGES = ROOT_W;            // one root bit per stage
   localparam int DEN_W       = DIFF_W + 1;        // divisor width
   localparam int DS_W        = WORD_BITS + 4;     // arc offset
   localparam int IPROD_W     = YAW_W + DS_W;      // difference times offset
   localparam int NUM_W       = IPROD_W + 2;       // dividend width
   localparam int DIV_STAGES  = NUM_W;             // one quotient bit per stage
   localparam int SPAN_MIN_W  = 17;
   localparam int STATUS_W    = 2;

   localparam logic [SPAN_MIN_W-1:0] SPAN_MIN_RESET = SPAN_MIN_W'(66);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SPAN = 2'd2;

   // pi and 2pi rounded to nearest at FRAC_BITS
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_RND = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
   localparam logic [63:0] TWO_PI_RND =
      (PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
   localparam logic signed [YAW_W-1:0] PI_Q     = YAW_W'(PI_RND);
   localparam logic signed [YAW_W-1:0] TWO_PI_Q = YAW_W'(TWO_PI_RND);

   // request and response items
   typedef struct packed {
      logic signed [WORD_BITS-1:0] start_x;
      logic signed [WORD_BITS-1:0] start_y;
      logic signed [WORD_BITS-1:0] start_yaw;
      logic signed [WORD_BITS-1:0] start_arc;
      logic signed [WORD_BITS-1:0] end_x;
      logic signed [WORD_BITS-1:0] end_y;
      logic signed [WORD_BITS-1:0] end_yaw;
      logic signed [WORD_BITS-1:0] end_arc;
      logic signed [WORD_BITS-1:0] car_x;
      logic signed [WORD_BITS-1:0] car_y;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] proj_x;
      logic signed [WORD_BITS-1:0] proj_y;
      logic signed [WORD_BITS-1:0] proj_yaw;
      logic signed [WORD_BITS-1:0] proj_arc;
      logic [STATUS_W-1:0]         status;
   } rsp_type;

endpackage

[sv/spi_sqrt.sv]
// ----------------------------------------------------------------------------
// spi_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module spi_sqrt (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [spi_pkg::RAD_W-1:0]    radicand,
   output logic [spi_pkg::ROOT_W-1:0]   root
);
   import spi_pkg::*;

   logic [RAD_W:0]    rem_ff  [SQRT_STAGES];
   logic [RAD_W:0]    rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in [SQRT_STAGES];

   // one trial subtraction per stage, most significant root bit first
   always_comb begin
      logic [RAD_W:0]    rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [RAD_W:0]    trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            rem_cur  = {1'b0, radicand};
            root_cur = '0;
         end else begin
            rem_cur  = rem_ff[j-1];
            root_cur = root_ff[j-1];
         end
         trial = ((RAD_W+1)'(root_cur) << (SQRT_STAGES - j))
               | ((RAD_W+1)'(1) << (2 * (SQRT_STAGES - 1 - j)));
         if (rem_cur >= trial) begin
            rem_in[j]  = rem_cur - trial;
            root_in[j] = root_cur | (ROOT_W'(1) << (SQRT_STAGES - 1 - j));
         end else begin
            rem_in[j]  = rem_cur;
            root_in[j] = root_cur;
         end
      end
   end

   // stage registers advance together
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

[sv/spi_div.sv]
// ----------------------------------------------------------------------------
// spi_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module spi_div (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [spi_pkg::NUM_W-1:0]   dividend,
   input  logic [spi_pkg::DEN_W-1:0]   divisor,
   output logic [spi_pkg::NUM_W-1:0]   quotient
);
   import spi_pkg::*;

   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DEN_W-1:0] rem_in [DIV_STAGES];
   logic [NUM_W-1:0] nq_ff  [DIV_STAGES];
   logic [NUM_W-1:0] nq_in  [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_in [DIV_STAGES];

   // shift in one dividend bit, compare, subtract
   always_comb begin
      logic [DEN_W-1:0] rem_cur;
      logic [NUM_W-1:0] nq_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0]   part;
      logic [DEN_W:0]   diff;
      logic             ge;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            rem_cur = '0;
            nq_cur  = dividend;
            den_cur = divisor;
         end else begin
            rem_cur = rem_ff[j-1];
            nq_cur  = nq_ff[j-1];
            den_cur = den_ff[j-1];
         end
         part = {rem_cur, nq_cur[NUM_W-1]};
         diff = part - {1'b0, den_cur};
         ge   = (part >= {1'b0, den_cur});
         rem_in[j] = ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
         nq_in[j]  = {nq_cur[NUM_W-2:0], ge};
         den_in[j] = den_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            rem_ff[j] <= rem_in[j];
            nq_ff[j]  <= nq_in[j];
            den_ff[j] <= den_in[j];
         end
      end
   end

   assign quotient = nq_ff[DIV_STAGES-1];

endmodule

[sv/segment_projection_interpolator.sv]
// ----------------------------------------------------------------------------
// segment_projection_interpolator: projects a point onto a path segment
// Arc offset = dot / floor(sqrt(len2)); x, y and wrapped yaw interpolated
// over the arc span; saturating Q16.16 results with a status code.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake           payload
//   req_*        in          req_valid/stall     req_type (segment + point)
//   rsp_*        out         rsp_valid/stall     rsp_type (projection+status)
//   csr_*        in          csr_valid/ready     yaw_span_min, 17 bits
//
// One item per cycle enters unless a held result stalls; the root and
// the chained arc and interpolation dividers make up most of the depth.
// All stages advance together; a stall at rsp with a result held holds
// every stage and asserts req_stall in the same cycle. Reset clears the
// valid bits and presets yaw_span_min (66) only; csr_ready is always high.
//
module segment_projection_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  spi_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output spi_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spi_pkg::SPAN_MIN_W-1:0]     csr_data
);
   import spi_pkg::*;

   localparam int SUM_W = NUM_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [WORD_BITS-1:0] sx;
      logic [WORD_BITS-1:0] sy;
      logic [WORD_BITS-1:0] syaw;
      logic [WORD_BITS-1:0] sarc;
   } base_type;

   typedef struct packed {
      base_type            base;
      logic [DIFF_W-1:0]   dx;
      logic [DIFF_W-1:0]   dy;
      logic [DIFF_W-1:0]   span;
      logic [YAW_W-1:0]    dw;
      logic [STATUS_W-1:0] status;
   } mid_type;

   typedef struct packed {
      mid_type           mid;
      logic [DIFF_W-1:0] v0x;
      logic [DIFF_W-1:0] v0y;
   } a_type;

   typedef struct packed {
      mid_type           mid;
      logic [PROD_W-1:0] xx;
      logic [PROD_W-1:0] yy;
      logic [PROD_W-1:0] px;
      logic [PROD_W-1:0] py;
   } b_type;

   typedef struct packed {
      mid_type          mid;
      logic [DOT_W-1:0] dot;
      logic [RAD_W-1:0] len2;
   } c_type;

   typedef struct packed {
      mid_type          mid;
      logic [DOT_W-1:0] dot_mag;
      logic             dot_neg;
   } sq_type;

   typedef struct packed {
      mid_type mid;
      logic    dot_neg;
   } d1_type;

   typedef struct packed {
      mid_type         mid;
      logic [DS_W-1:0] ds;
   } e_type;

   typedef struct packed {
      mid_type              mid;
      logic [IPROD_W-1:0]   px;
      logic [IPROD_W-1:0]   py;
      logic [IPROD_W-1:0]   pw;
      logic [DIFF_W-1:0]    span_mag;
      logic [WORD_BITS-1:0] arc;
      logic                 yaw_hold;
   } f_type;

   typedef struct packed {
      base_type             base;
      logic [STATUS_W-1:0]  status;
      logic [WORD_BITS-1:0] arc;
      logic                 yaw_hold;
      logic                 nx;
      logic                 ny;
      logic                 nw;
   } d2_type;

   // saturate a wide signed sum to one word
   function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic [WORD_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[WORD_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[WORD_BITS-1:0];
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   logic adv;

   logic [SPAN_MIN_W-1:0] span_min_ff;

   a_type  a_ff, a_in;
   b_type  b_ff, b_in;
   c_type  c_ff, c_in;
   e_type  e_ff, e_in;
   f_type  f_ff, f_in;
   d2_type g_ff, g_in;
   logic [NUM_W-1:0] g_mx_ff, g_my_ff, g_mw_ff;
   logic [NUM_W-1:0] g_mx_in, g_my_in, g_mw_in;
   logic [DEN_W-1:0] g_span_ff;

   logic va_ff, vb_ff, vc_ff, ve_ff, vf_ff, vg_ff;
   logic [SQRT_STAGES-1:0] sq_v_ff;
   logic [DIV_STAGES-1:0]  d1_v_ff;
   logic [DIV_STAGES-1:0]  d2_v_ff;

   sq_type sq_line_ff [SQRT_STAGES];
   d1_type d1_line_ff [DIV_STAGES];
   d2_type d2_line_ff [DIV_STAGES];

   logic [ROOT_W-1:0] len_root;
   logic [NUM_W-1:0]  ds_quot;
   logic [NUM_W-1:0]  qx, qy, qw;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // the whole pipeline moves unless a finished result is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         span_min_ff <= SPAN_MIN_RESET;
      end else if (csr_valid && csr_ready) begin
         span_min_ff <= csr_data;
      end
   end

   // stage a: differences and status
   always_comb begin
      a_in.mid.base.sx   = req_data.start_x;
      a_in.mid.base.sy   = req_data.start_y;
      a_in.mid.base.syaw = req_data.start_yaw;
      a_in.mid.base.sarc = req_data.start_arc;
      a_in.mid.dx   = {req_data.end_x[WORD_BITS-1], req_data.end_x}
                    - {req_data.start_x[WORD_BITS-1], req_data.start_x};
      a_in.mid.dy   = {req_data.end_y[WORD_BITS-1], req_data.end_y}
                    - {req_data.start_y[WORD_BITS-1], req_data.start_y};
      a_in.mid.span = {req_data.end_arc[WORD_BITS-1], req_data.end_arc}
                    - {req_data.start_arc[WORD_BITS-1], req_data.start_arc};
      a_in.mid.dw   = {{2{req_data.end_yaw[WORD_BITS-1]}}, req_data.end_yaw}
                    - {{2{req_data.start_yaw[WORD_BITS-1]}}, req_data.start_yaw};
      a_in.v0x      = {req_data.car_x[WORD_BITS-1], req_data.car_x}
                    - {req_data.start_x[WORD_BITS-1], req_data.start_x};
      a_in.v0y      = {req_data.car_y[WORD_BITS-1], req_data.car_y}
                    - {req_data.start_y[WORD_BITS-1], req_data.start_y};
      if (a_in.mid.dx == '0 && a_in.mid.dy == '0) begin
         a_in.mid.status = STATUS_ZERO_LEN;
      end else if (a_in.mid.span == '0) begin
         a_in.mid.status = STATUS_ZERO_SPAN;
      end else begin
         a_in.mid.status = STATUS_OK;
      end
   end

   // stage b: products and heading wrap
   always_comb begin
      b_in.mid = a_ff.mid;
      b_in.xx  = $signed(a_ff.mid.dx) * $signed(a_ff.mid.dx);
      b_in.yy  = $signed(a_ff.mid.dy) * $signed(a_ff.mid.dy);
      b_in.px  = $signed(a_ff.v0x) * $signed(a_ff.mid.dx);
      b_in.py  = $signed(a_ff.v0y) * $signed(a_ff.mid.dy);
      if ($signed(a_ff.mid.dw) > PI_Q) begin
         b_in.mid.dw = a_ff.mid.dw - TWO_PI_Q;
      end else if ($signed(a_ff.mid.dw) < -PI_Q) begin
         b_in.mid.dw = a_ff.mid.dw + TWO_PI_Q;
      end
   end

   // stage c: squared length and dot product
   always_comb begin
      c_in.mid  = b_ff.mid;
      c_in.len2 = b_ff.xx + b_ff.yy;
      c_in.dot  = {b_ff.px[PROD_W-1], b_ff.px} + {b_ff.py[PROD_W-1], b_ff.py};
   end

   // front registers
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   // segment length
   spi_sqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (c_ff.len2),
      .root     (len_root)
   );

   // side data alongside the root, dot magnitude taken on entry
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_line_ff[0].mid     <= c_ff.mid;
         sq_line_ff[0].dot_neg <= c_ff.dot[DOT_W-1];
         sq_line_ff[0].dot_mag <= c_ff.dot[DOT_W-1] ? (~c_ff.dot + 1'b1) : c_ff.dot;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sq_line_ff[k] <= sq_line_ff[k-1];
         end
      end
   end

   // arc offset divider
   spi_div u_div_ds (
      .clock    (clock),
      .enable   (adv),
      .dividend (NUM_W'(sq_line_ff[SQRT_STAGES-1].dot_mag)),
      .divisor  (DEN_W'(len_root)),
      .quotient (ds_quot)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_line_ff[0].mid     <= sq_line_ff[SQRT_STAGES-1].mid;
         d1_line_ff[0].dot_neg <= sq_line_ff[SQRT_STAGES-1].dot_neg;
         for (int k = 1; k < DIV_STAGES; k++) begin
            d1_line_ff[k] <= d1_line_ff[k-1];
         end
      end
   end

   // stage e: signed arc offset
   always_comb begin
      logic [DS_W-1:0] mag;
      mag      = {1'b0, ds_quot[DS_W-2:0]};
      e_in.mid = d1_line_ff[DIV_STAGES-1].mid;
      e_in.ds  = d1_line_ff[DIV_STAGES-1].dot_neg ? (~mag + 1'b1) : mag;
   end

   // stage f: interpolation products, projected arc, short span flag
   always_comb begin
      f_in.mid      = e_ff.mid;
      f_in.px       = $signed(e_ff.mid.dx) * $signed(e_ff.ds);
      f_in.py       = $signed(e_ff.mid.dy) * $signed(e_ff.ds);
      f_in.pw       = $signed(e_ff.mid.dw) * $signed(e_ff.ds);
      f_in.span_mag = e_ff.mid.span[DIFF_W-1] ? (~e_ff.mid.span + 1'b1) : e_ff.mid.span;
      f_in.yaw_hold = (f_in.span_mag <= DIFF_W'(span_min_ff));
      f_in.arc      = sat_word(SUM_W'($signed(e_ff.mid.base.sarc)) + SUM_W'($signed(e_ff.ds)));
   end

   // stage g: magnitudes and quotient signs
   always_comb begin
      logic [IPROD_W-1:0] mag_x, mag_y, mag_w;
      mag_x       = f_ff.px[IPROD_W-1] ? (~f_ff.px + 1'b1) : f_ff.px;
      mag_y       = f_ff.py[IPROD_W-1] ? (~f_ff.py + 1'b1) : f_ff.py;
      mag_w       = f_ff.pw[IPROD_W-1] ? (~f_ff.pw + 1'b1) : f_ff.pw;
      g_in.base     = f_ff.mid.base;
      g_in.status   = f_ff.mid.status;
      g_in.arc      = f_ff.arc;
      g_in.yaw_hold = f_ff.yaw_hold;
      g_in.nx       = f_ff.px[IPROD_W-1] ^ f_ff.mid.span[DIFF_W-1];
      g_in.ny       = f_ff.py[IPROD_W-1] ^ f_ff.mid.span[DIFF_W-1];
      g_in.nw       = f_ff.pw[IPROD_W-1] ^ f_ff.mid.span[DIFF_W-1];
      g_mx_in       = NUM_W'(mag_x);
      g_my_in       = NUM_W'(mag_y);
      g_mw_in       = NUM_W'(mag_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
         d1_v_ff <= '0;
         ve_ff   <= 1'b0;
         vf_ff   <= 1'b0;
         vg_ff   <= 1'b0;
      end else if (adv) begin
         sq_v_ff <= {sq_v_ff[SQRT_STAGES-2:0], vc_ff};
         d1_v_ff <= {d1_v_ff[DIV_STAGES-2:0], sq_v_ff[SQRT_STAGES-1]};
         ve_ff   <= d1_v_ff[DIV_STAGES-1];
         vf_ff   <= ve_ff;
         vg_ff   <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff      <= e_in;
         f_ff      <= f_in;
         g_ff      <= g_in;
         g_mx_ff   <= g_mx_in;
         g_my_ff   <= g_my_in;
         g_mw_ff   <= g_mw_in;
         g_span_ff <= DEN_W'(f_ff.span_mag);
      end
   end

   // interpolation dividers
   spi_div u_div_x (
      .clock    (clock),
      .enable   (adv),
      .dividend (g_mx_ff),
      .divisor  (g_span_ff),
      .quotient (qx)
   );

   spi_div u_div_y (
      .clock    (clock),
      .enable   (adv),
      .dividend (g_my_ff),
      .divisor  (g_span_ff),
      .quotient (qy)
   );

   spi_div u_div_w (
      .clock    (clock),
      .enable   (adv),
      .dividend (g_mw_ff),
      .divisor  (g_span_ff),
      .quotient (qw)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_line_ff[0] <= g_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            d2_line_ff[k] <= d2_line_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff <= '0;
      end else if (adv) begin
         d2_v_ff <= {d2_v_ff[DIV_STAGES-2:0], vg_ff};
      end
   end

   // output stage: sign, add base, saturate, pick special cases
   always_comb begin
      d2_type           t;
      logic [SUM_W-1:0] ux, uy, uw;
      logic [SUM_W-1:0] sx_q, sy_q, sw_q;
      t    = d2_line_ff[DIV_STAGES-1];
      ux   = {2'b00, qx};
      uy   = {2'b00, qy};
      uw   = {2'b00, qw};
      sx_q = t.nx ? (~ux + 1'b1) : ux;
      sy_q = t.ny ? (~uy + 1'b1) : uy;
      sw_q = t.nw ? (~uw + 1'b1) : uw;
      rsp_data_in.status = t.status;
      if (t.status != STATUS_OK) begin
         rsp_data_in.proj_x   = t.base.sx;
         rsp_data_in.proj_y   = t.base.sy;
         rsp_data_in.proj_yaw = t.base.syaw;
         rsp_data_in.proj_arc = t.base.sarc;
      end else begin
         rsp_data_in.proj_x   = sat_word($signed(sx_q) + SUM_W'($signed(t.base.sx)));
         rsp_data_in.proj_y   = sat_word($signed(sy_q) + SUM_W'($signed(t.base.sy)));
         rsp_data_in.proj_yaw = t.yaw_hold ? t.base.syaw
                              : sat_word($signed(sw_q) + SUM_W'($signed(t.base.syaw)));
         rsp_data_in.proj_arc = t.arc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a delivered status is always one of the defined codes
   a_status_legal: assert property (@(posedge clock)
      rsp_valid_ff |-> (rsp_data_ff.status == STATUS_OK
                     || rsp_data_ff.status == STATUS_ZERO_LEN
                     || rsp_data_ff.status == STATUS_ZERO_SPAN))
      else $error("illegal status code on rsp");

   // a held pipeline keeps the root stage frozen
   a_root_hold: assert property (@(posedge clock)
      !adv |=> $stable(len_root))
      else $error("segment length changed while pipeline held");

   // reset empties the pipeline ends
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !va_ff && !vg_ff))
      else $error("valid bits survived reset");

endmodule
